FILE: hdl/string_escape_decoder_top_assert.svh
// Assertion macros for the escape decoder RTL; sed_fifo is the file that includes them.
// Include by bare file name inside a module that has i_clk and i_rst_n.
`ifndef STRING_ESCAPE_DECODER_TOP_ASSERT_SVH
`define STRING_ESCAPE_DECODER_TOP_ASSERT_SVH

// Clocked check, disabled while reset is held.
`define SED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked check that also holds across reset.
`define SED_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: hdl/sed_pkg.sv
// Package for the string escape decoder: mode enum, queue entry type,
// character codes and small decode functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_WARN = 1'b1;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_UP_C   = 8'h43;
    localparam logic [7:0] CH_UP_M   = 8'h4D;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    typedef enum logic [2:0] {
        MD_PLAIN = 3'd0,
        MD_ESC   = 3'd1,
        MD_OCT   = 3'd2,
        MD_HEX   = 3'd3,
        MD_CR    = 3'd4,
        MD_PFX   = 3'd5,
        MD_DASH  = 3'd6
    } t_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_result;

    // One entry per input byte that yields results; r0 goes out first.
    typedef struct packed {
        logic    two;
        t_result r1;
        t_result r0;
    } t_entry;

    // {hit, value} for the named control escapes.
    function automatic logic [8:0] esc_named(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h6E:   r = {1'b1, 8'h0A};   // n
            8'h74:   r = {1'b1, 8'h09};   // t
            8'h72:   r = {1'b1, 8'h0D};   // r
            8'h66:   r = {1'b1, 8'h0C};   // f
            8'h76:   r = {1'b1, 8'h0B};   // v
            8'h61:   r = {1'b1, 8'h07};   // a
            8'h65:   r = {1'b1, 8'h1B};   // e
            8'h62:   r = {1'b1, 8'h08};   // b
            8'h73:   r = {1'b1, 8'h20};   // s
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

    // {valid, nibble} for a hex digit.
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/string_escape_decoder_top.sv
// Escape decoder top: an accepted input beat's first result passes the queue, then the output register.
// One input beat per cycle while the queue has room; output gives one beat per
// cycle while m_axis_tready is high, so a byte that yields two results takes two output beats.
// Queue of QUEUE_DEPTH entries decouples the escape state machine from output.
// Synchronous active-low reset clears mode, digit state, config and the queue.
`timescale 1ns / 1ps
`default_nettype none

module string_escape_decoder_top #(
    parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,  // keep_escaped_newline
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
    input  wire logic       s_axis_tlast,   // last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // kind
    output logic            m_axis_tlast    // last result of the queue entry
);
    import sed_pkg::*;

    t_entry push_ent, head_ent;
    logic   push, pop, full, empty;

    sed_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_ent)
    );

    sed_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_ent),
        .i_pop   (pop),
        .o_entry (head_ent),
        .o_full  (full),
        .o_empty (empty)
    );

    sed_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_ent),
        .i_empty       (empty),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: hdl/sed_front.sv
// Front end of the escape decoder: input handshake, escape state machine,
// configuration register. Pushes one queue entry per byte with results. Uses sed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sed_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr_en,
    input  wire logic            i_cfg_wr_data,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [7:0]      s_axis_tdata,   // [7:0] ch
    input  wire logic            s_axis_tlast,   // last
    input  wire logic            i_full,
    output logic                 o_push,
    output sed_pkg::t_entry      o_entry
);
    import sed_pkg::*;

    t_mode      r_mode, n_mode, s_mode;
    logic [7:0] r_accum, n_accum, s_accum;
    logic [1:0] r_count, n_count, s_count;
    logic       r_keep_nl;

    logic       accept;
    logic [7:0] c;
    logic       c_bs;
    logic [8:0] named;
    logic [4:0] hx;
    logic [1:0] res_cnt;
    t_result    res0, res1;

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;
    assign c_bs          = (c == CH_BSLASH);
    assign named         = esc_named(c);
    assign hx            = hex_nib(c);

    // Next state for this byte, before the end-of-run flush.
    always_comb begin
        s_mode  = r_mode;
        s_accum = r_accum;
        s_count = r_count;
        unique case (r_mode)
            MD_ESC: begin
                s_mode = MD_PLAIN;
                if (c == CH_CR) begin
                    s_mode = MD_CR;
                end else if (c == CH_LOW_C) begin
                    s_mode = MD_PFX;
                end else if (c == CH_UP_C || c == CH_UP_M) begin
                    s_mode = MD_DASH;
                end else if (c == CH_LOW_X) begin
                    s_accum = 8'h00;
                    s_count = 2'd0;
                    s_mode  = MD_HEX;
                end else if (c != CH_LF && !named[8] && is_oct(c)) begin
                    s_accum = {5'b0, c[2:0]};
                    s_count = 2'd1;
                    s_mode  = MD_OCT;
                end
            end
            MD_OCT: begin
                if (is_oct(c)) begin
                    if (r_count == 2'd2) begin
                        s_accum = 8'h00;
                        s_count = 2'd0;
                        s_mode  = MD_PLAIN;
                    end else begin
                        s_accum = {r_accum[4:0], c[2:0]};
                        s_count = r_count + 2'd1;
                    end
                end else begin
                    s_accum = 8'h00;
                    s_count = 2'd0;
                    s_mode  = c_bs ? MD_ESC : MD_PLAIN;
                end
            end
            MD_HEX: begin
                if (hx[4]) begin
                    if (r_count == 2'd1) begin
                        s_accum = 8'h00;
                        s_count = 2'd0;
                        s_mode  = MD_PLAIN;
                    end else begin
                        s_accum = {r_accum[3:0], hx[3:0]};
                        s_count = r_count + 2'd1;
                    end
                end else begin
                    s_accum = 8'h00;
                    s_count = 2'd0;
                    s_mode  = c_bs ? MD_ESC : MD_PLAIN;
                end
            end
            MD_CR: begin
                s_mode = (c != CH_LF && c_bs) ? MD_ESC : MD_PLAIN;
            end
            MD_DASH: begin
                if (c == CH_DASH) begin
                    s_mode = MD_PFX;
                end else begin
                    s_mode = c_bs ? MD_ESC : MD_PLAIN;
                end
            end
            MD_PFX: begin
                s_mode = c_bs ? MD_ESC : MD_PLAIN;
            end
            default: begin
                s_mode = c_bs ? MD_ESC : MD_PLAIN;
            end
        endcase
    end

    // Last byte of a run returns everything to reset.
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        n_count = r_count;
        if (accept) begin
            if (s_axis_tlast) begin
                n_mode  = MD_PLAIN;
                n_accum = 8'h00;
                n_count = 2'd0;
            end else begin
                n_mode  = s_mode;
                n_accum = s_accum;
                n_count = s_count;
            end
        end
    end

    // Results caused by this byte.
    always_comb begin
        res_cnt = 2'd0;
        res0    = '{kind: KIND_DATA, data: c};
        res1    = '{kind: KIND_DATA, data: c};
        unique case (r_mode)
            MD_ESC: begin
                if (c == CH_LF) begin
                    res0.data = CH_LF;
                    res_cnt   = r_keep_nl ? 2'd1 : 2'd0;
                end else if (named[8]) begin
                    res0.data = named[7:0];
                    res_cnt   = 2'd1;
                end else if (c != CH_CR && c != CH_LOW_C && c != CH_UP_C && c != CH_UP_M
                             && c != CH_LOW_X && !is_oct(c)) begin
                    res_cnt = 2'd1;
                end
            end
            MD_OCT: begin
                if (is_oct(c)) begin
                    if (r_count == 2'd2) begin
                        res0.data = {r_accum[4:0], c[2:0]};
                        res_cnt   = 2'd1;
                    end
                end else begin
                    res0.data = r_accum;
                    res_cnt   = c_bs ? 2'd1 : 2'd2;
                end
            end
            MD_HEX: begin
                if (hx[4]) begin
                    if (r_count == 2'd1) begin
                        res0.data = {r_accum[3:0], hx[3:0]};
                        res_cnt   = 2'd1;
                    end
                end else begin
                    res0.data = r_accum;
                    res_cnt   = c_bs ? 2'd1 : 2'd2;
                end
            end
            MD_CR: begin
                if (c == CH_LF) begin
                    res_cnt = r_keep_nl ? 2'd1 : 2'd0;
                end else if (!c_bs) begin
                    res_cnt = 2'd1;
                end
            end
            MD_DASH: begin
                if (c != CH_DASH) begin
                    res0    = '{kind: KIND_WARN, data: 8'h00};
                    res_cnt = c_bs ? 2'd1 : 2'd2;
                end
            end
            MD_PFX: begin
                res_cnt = c_bs ? 2'd0 : 2'd1;
            end
            default: begin
                res_cnt = c_bs ? 2'd0 : 2'd1;
            end
        endcase
        // Flush only follows a byte that itself gave no result.
        if (s_axis_tlast) begin
            if (s_mode == MD_OCT || s_mode == MD_HEX) begin
                res0    = '{kind: KIND_DATA, data: s_accum};
                res_cnt = 2'd1;
            end else if (s_mode == MD_DASH) begin
                res0    = '{kind: KIND_WARN, data: 8'h00};
                res_cnt = 2'd1;
            end
        end
    end

    assign o_push        = accept && (res_cnt != 2'd0);
    assign o_entry.two   = (res_cnt == 2'd2);
    assign o_entry.r0    = res0;
    assign o_entry.r1    = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MD_PLAIN;
            r_accum   <= 8'h00;
            r_count   <= 2'd0;
            r_keep_nl <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_keep_nl <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sed_fifo.sv
// Short queue of result entries between front and back of the escape decoder.
// Uses sed_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "string_escape_decoder_top_assert.svh"

module sed_fifo #(
    parameter int DEPTH = sed_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sed_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output sed_pkg::t_entry      o_entry,
    output logic                 o_full,
    output logic                 o_empty
);
    import sed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SED_ASSERT(a_no_overflow, !(i_push && o_full), "push into full queue")
    `SED_ASSERT(a_no_underflow, !(i_pop && o_empty), "pop from empty queue")
    `SED_ASSERT(a_count_up, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1),
        "queue count did not follow a push")
    `SED_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> o_empty, "queue not empty after reset")

endmodule

`default_nettype wire

FILE: hdl/sed_back.sv
// Back end of the escape decoder: takes queue entries and sends their one or
// two results as output beats from an output register. Uses sed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sed_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sed_pkg::t_entry i_entry,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
    output logic                 m_axis_tuser,   // kind
    output logic                 m_axis_tlast    // last result of the queue entry
);
    import sed_pkg::*;

    t_entry  r_ent;
    logic    r_valid;
    logic    r_idx;
    logic    take;
    logic    ent_done;
    t_result cur;

    assign cur      = r_idx ? r_ent.r1 : r_ent.r0;
    assign take     = r_valid && m_axis_tready;
    assign ent_done = take && (r_idx || !r_ent.two);
    assign o_pop    = !i_empty && (!r_valid || ent_done);

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = cur.data;
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = r_idx || !r_ent.two;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 1'b0;
        end else if (ent_done) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (take) begin
            // advance to the second result of the entry
            r_idx <= 1'b1;
        end
    end

endmodule

`default_nettype wire
